### rtl/core/swtg_pkg.sv
// shared types and constants of the square wave tone generator
package swtg_pkg;

    localparam int OP_W        = 2;
    localparam int FREQ_W      = 16;
    localparam int DUR_W       = 16;
    localparam int AMP_W       = 15;
    localparam int SAMPLE_W    = 16;
    localparam int DUR_MAX     = (1 << DUR_W) - 1;
    localparam int MS_PER_S    = 1000;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [AMP_W-1:0] AMP_RESET = 15'h7FFF;

    typedef enum logic [OP_W-1:0] {
        OP_PLAY = 2'd0,
        OP_STOP = 2'd1,
        OP_TICK = 2'd2
    } op_t;

    typedef enum logic {
        BK_IDLE   = 1'b0,
        BK_DIVIDE = 1'b1
    } back_state_t;

    typedef struct packed {
        op_t               kind;
        logic [FREQ_W-1:0] freq;
        logic [DUR_W-1:0]  dur;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } queue_head_t;

endpackage

### rtl/core/square_wave_tone_generator_top.sv
// top level of the square wave tone generator
// Square wave tone generator. Items arrive on a valid/ready channel: op 0 plays a tone of
// freq_hz for duration_ms (frequency 0 is a rest, duration 0 plays until the next play or
// stop), op 1 stops the tone, op 2 is one sample tick and op 3 is taken and ignored. Only a
// tick yields a result: one signed sample on the output channel, -amplitude in the first
// half-wave, +amplitude in the next, alternating, or 0 when no tone is active. The amplitude
// register is written through amplitude_we/amplitude and resets to full scale; the user is to
// write it only while the block is idle, and the block itself does not enforce this. A front end
// queues up to two commands while the back end works, so input transfers continue during a
// play setup. Stop and tick are retired from the idle state of the back end (a tick also
// needs the output register free). A play is set up by the bit-serial divider that forms
// the half-wave length SAMPLE_RATE / (2 * freq_hz) one quotient bit per cycle: a start
// step, then the divide steps and a step that loads the result; the sample budget
// duration_ms * SAMPLE_RATE / 1000 comes from a reciprocal multiply in that last step.
module square_wave_tone_generator_top #(
    parameter int SAMPLE_RATE = 22050
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // input channel
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [swtg_pkg::OP_W-1:0]     op,
    input  logic [swtg_pkg::FREQ_W-1:0]   freq_hz,
    input  logic [swtg_pkg::DUR_W-1:0]    duration_ms,
    // result channel
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [swtg_pkg::SAMPLE_W-1:0] sample,
    // amplitude register write
    input  logic                          amplitude_we,
    input  logic [swtg_pkg::AMP_W-1:0]    amplitude
);
    import swtg_pkg::*;

    logic [AMP_W-1:0]    amplitude_reg;
    queue_head_t         head;
    logic                pop;
    logic [SAMPLE_W-1:0] sample_bits;

    // amplitude register, written without handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            amplitude_reg <= AMP_RESET;
        end
        else if (amplitude_we)
        begin
            amplitude_reg <= amplitude;
        end
    end

    // front: accepts transfers and queues play, stop and tick commands in order
    swtg_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .op          (op),
        .freq_hz     (freq_hz),
        .duration_ms (duration_ms),
        .pop         (pop),
        .head        (head)
    );

    // back: runs the divider for play, keeps the wave state, drives the output register
    swtg_back #(
        .SAMPLE_RATE (SAMPLE_RATE)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .pop       (pop),
        .amp       (amplitude_reg),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sample    (sample_bits)
    );

    assign sample = $signed(sample_bits);

endmodule

### rtl/core/swtg_div.sv
// bit-serial restoring divider, one quotient bit per cycle
module swtg_div #(
    parameter int NUM_W = 16,
    parameter int DEN_W = 17
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] dividend,
    input  logic [DEN_W-1:0] divisor,
    output logic             busy,
    output logic [NUM_W-1:0] quotient
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] rem_next;
    logic [NUM_W-1:0] quot_reg;
    logic [NUM_W-1:0] quot_next;
    logic [DEN_W-1:0] div_reg;
    logic [DEN_W-1:0] div_next;
    logic [DEN_W:0]   shifted;
    logic [DEN_W+1:0] diff;

    assign shifted = {rem_reg, quot_reg[NUM_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, div_reg};

    always_comb
    begin
        count_next = count_reg;
        rem_next   = rem_reg;
        quot_next  = quot_reg;
        div_next   = div_reg;
        if (start)
        begin
            count_next = CNT_W'(NUM_W);
            rem_next   = '0;
            quot_next  = dividend;
            div_next   = divisor;
        end
        else if (count_reg != '0)
        begin
            count_next = count_reg - 1'b1;
            // no borrow means the divisor fits
            if (!diff[DEN_W+1])
            begin
                rem_next  = diff[DEN_W-1:0];
                quot_next = {quot_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = shifted[DEN_W-1:0];
                quot_next = {quot_reg[NUM_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        div_reg  <= div_next;
    end

    assign busy     = (count_reg != '0);
    assign quotient = quot_reg;

endmodule

### rtl/core/swtg_front.sv
// front end: takes input transfers, drops unused codes, queues commands
module swtg_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [swtg_pkg::OP_W-1:0]   op,
    input  logic [swtg_pkg::FREQ_W-1:0] freq_hz,
    input  logic [swtg_pkg::DUR_W-1:0]  duration_ms,
    input  logic                        pop,
    output swtg_pkg::queue_head_t       head
);
    import swtg_pkg::*;

    cmd_t              queue_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              known_op;
    logic              push;
    logic              do_pop;

    always_comb
    begin
        unique case (op) inside
            OP_PLAY, OP_STOP, OP_TICK: known_op = 1'b1;
            default:                   known_op = 1'b0;
        endcase
    end

    assign in_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    // unused code 3 is taken and dropped here
    assign push     = in_valid && in_ready && known_op;
    assign do_pop   = pop && (count_reg != '0);

    always_comb
    begin
        wr_ptr_next = push   ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_mem[wr_ptr_reg] <= '{kind: op_t'(op), freq: freq_hz, dur: duration_ms};
        end
    end

    assign head.valid = (count_reg != '0);
    assign head.cmd   = queue_mem[rd_ptr_reg];

endmodule

### rtl/core/swtg_back.sv
// back end: tone state, play setup through the half-wave divider, sample output register
module swtg_back #(
    parameter int SAMPLE_RATE = 22050
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  swtg_pkg::queue_head_t         head,
    output logic                          pop,
    input  logic [swtg_pkg::AMP_W-1:0]    amp,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [swtg_pkg::SAMPLE_W-1:0] sample
);
    import swtg_pkg::*;

    localparam int                  SR_W     = $clog2(SAMPLE_RATE + 1);
    localparam int                  HALF_W   = $clog2(SAMPLE_RATE / 2 + 1);
    localparam longint unsigned     MAX_PROD = 64'(DUR_MAX) * 64'(SAMPLE_RATE);
    localparam int                  LEFT_W   = $clog2(MAX_PROD / MS_PER_S + 1);
    // budget = dur * SAMPLE_RATE / 1000 as dur * ceil(SAMPLE_RATE * 2^26 / 1000) >> 26,
    // exact for every 16-bit duration since the excess stays below 1/1000
    localparam int                  RECIP_SHIFT = 26;
    localparam int                  RECIP_W     = 32;
    localparam longint unsigned     RECIP       =
        ((64'(SAMPLE_RATE) << RECIP_SHIFT) + 64'(MS_PER_S - 1)) / 64'(MS_PER_S);
    localparam int                  LPROD_W     = DUR_W + RECIP_W;

    back_state_t       state_reg;
    back_state_t       state_next;
    logic [HALF_W-1:0] half_len_reg;
    logic [HALF_W-1:0] half_len_next;
    logic [HALF_W-1:0] phase_count_reg;
    logic [HALF_W-1:0] phase_count_next;
    logic              phase_high_reg;
    logic              phase_high_next;
    logic [LEFT_W-1:0] left_reg;
    logic [LEFT_W-1:0] left_next;
    logic              forever_reg;
    logic              forever_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [SAMPLE_W-1:0] sample_reg;
    logic [SAMPLE_W-1:0] sample_next;

    logic               div_start;
    logic               half_busy;
    logic [SR_W-1:0]    half_q;
    logic [LPROD_W-1:0] left_prod;
    logic [LEFT_W-1:0]  left_q;
    logic               slot_free;
    logic               tone_active;
    logic [HALF_W:0]    phase_inc;
    logic [SAMPLE_W-1:0] amp_ext;
    logic               divs_done;

    assign left_prod = LPROD_W'(head.cmd.dur) * LPROD_W'(RECIP);
    assign left_q    = left_prod[RECIP_SHIFT +: LEFT_W];

    swtg_div #(
        .NUM_W (SR_W),
        .DEN_W (FREQ_W + 1)
    ) u_half_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (SR_W'(SAMPLE_RATE)),
        .divisor  ({head.cmd.freq, 1'b0}),
        .busy     (half_busy),
        .quotient (half_q)
    );

    assign divs_done   = !half_busy;
    assign slot_free   = !out_valid_reg || out_ready;
    assign tone_active = (half_len_reg != '0) && (forever_reg || (left_reg != '0));
    assign phase_inc   = {1'b0, phase_count_reg} + 1'b1;
    assign amp_ext     = {1'b0, amp};

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (head.valid && (head.cmd.kind == OP_PLAY))
                begin
                    state_next = BK_DIVIDE;
                end
            end
            BK_DIVIDE:
            begin
                if (divs_done)
                begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // datapath and handshake outputs
    always_comb
    begin
        pop              = 1'b0;
        div_start        = 1'b0;
        half_len_next    = half_len_reg;
        phase_count_next = phase_count_reg;
        phase_high_next  = phase_high_reg;
        left_next        = left_reg;
        forever_next     = forever_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        sample_next      = sample_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (head.valid)
                begin
                    unique case (head.cmd.kind)
                        OP_PLAY:
                        begin
                            div_start = 1'b1;
                        end
                        OP_STOP:
                        begin
                            pop              = 1'b1;
                            half_len_next    = '0;
                            phase_count_next = '0;
                            phase_high_next  = 1'b0;
                            left_next        = '0;
                            forever_next     = 1'b0;
                        end
                        OP_TICK:
                        begin
                            if (slot_free)
                            begin
                                pop            = 1'b1;
                                out_valid_next = 1'b1;
                                sample_next    = '0;
                                if (tone_active)
                                begin
                                    sample_next = phase_high_reg ? amp_ext : (16'd0 - amp_ext);
                                    if (phase_inc >= {1'b0, half_len_reg})
                                    begin
                                        phase_count_next = '0;
                                        phase_high_next  = !phase_high_reg;
                                    end
                                    else
                                    begin
                                        phase_count_next = phase_inc[HALF_W-1:0];
                                    end
                                    if (!forever_reg)
                                    begin
                                        left_next = left_reg - 1'b1;
                                    end
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            BK_DIVIDE:
            begin
                if (divs_done)
                begin
                    pop              = 1'b1;
                    phase_count_next = '0;
                    phase_high_next  = 1'b0;
                    forever_next     = (head.cmd.dur == '0);
                    left_next        = left_q;
                    if (head.cmd.freq == '0)
                    begin
                        half_len_next = '0;
                    end
                    else if (half_q == '0)
                    begin
                        half_len_next = HALF_W'(1);
                    end
                    else
                    begin
                        half_len_next = half_q[HALF_W-1:0];
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= BK_IDLE;
            half_len_reg    <= '0;
            phase_count_reg <= '0;
            phase_high_reg  <= 1'b0;
            left_reg        <= '0;
            forever_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            half_len_reg    <= half_len_next;
            phase_count_reg <= phase_count_next;
            phase_high_reg  <= phase_high_next;
            left_reg        <= left_next;
            forever_reg     <= forever_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg <= sample_next;
    end

    assign out_valid = out_valid_reg;
    assign sample    = sample_reg;

    a_divide_pop_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_DIVIDE && pop) |-> !half_busy)
        else $error("play retired while the divider still runs");

    a_tick_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && head.cmd.kind == OP_TICK) |-> (!out_valid_reg || out_ready))
        else $error("tick retired with the output register still full");

    a_start_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> (state_reg == BK_IDLE && head.valid))
        else $error("divider started outside idle");

    a_tone_has_length: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_DIVIDE && divs_done && head.cmd.freq != '0) |=> (half_len_reg != '0))
        else $error("audible play left a zero half-wave length");

endmodule

### bench/tone_sample_checker.sv
// scoreboard for the square wave tone generator: predicts samples and compares them
module tone_sample_checker #(
    parameter int SAMPLE_RATE = 22050
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  logic                                 in_ready,
    input  logic [swtg_pkg::OP_W-1:0]            op,
    input  logic [swtg_pkg::FREQ_W-1:0]          freq_hz,
    input  logic [swtg_pkg::DUR_W-1:0]           duration_ms,
    input  logic                                 out_valid,
    input  logic                                 out_ready,
    input  logic signed [swtg_pkg::SAMPLE_W-1:0] sample,
    input  logic                                 amplitude_we,
    input  logic [swtg_pkg::AMP_W-1:0]           amplitude,
    output int                                   mismatches,
    output int                                   samples_pending,
    output int                                   samples_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    import swtg_pkg::*;

    // predicted tone state
    logic [AMP_W-1:0] level;
    logic [13:0]      half_len;
    logic [13:0]      phase_count;
    logic             phase_high;
    logic [20:0]      samples_left;
    logic             endless;

    logic signed [SAMPLE_W-1:0] expected_samples[$];

    function automatic void clear_tone();
        half_len     = '0;
        phase_count  = '0;
        phase_high   = 1'b0;
        samples_left = '0;
        endless      = 1'b0;
    endfunction

    // advance the tone state by one transfer, queue the sample a tick yields
    function automatic void advance_tone(logic [OP_W-1:0] kind, logic [FREQ_W-1:0] f,
                                         logic [DUR_W-1:0] d);
        logic [31:0] half;
        logic [31:0] budget;
        logic signed [SAMPLE_W-1:0] s;
        case (kind)
            OP_PLAY:
            begin
                half = 0;
                if (f != 0)
                begin
                    half = SAMPLE_RATE / (32'(f) * 2);
                    if (half == 0)
                        half = 1;
                end
                budget       = 32'(d) * SAMPLE_RATE / MS_PER_S;
                half_len     = half[13:0];
                samples_left = budget[20:0];
                endless      = (d == 0);
                phase_count  = '0;
                phase_high   = 1'b0;
            end
            OP_STOP:
                clear_tone();
            OP_TICK:
            begin
                s = '0;
                if (half_len != 0 && (endless || samples_left != 0))
                begin
                    s = phase_high ? $signed({1'b0, level}) : -$signed({1'b0, level});
                    phase_count = phase_count + 1'b1;
                    if (phase_count >= half_len)
                    begin
                        phase_count = '0;
                        phase_high  = ~phase_high;
                    end
                    if (!endless)
                        samples_left = samples_left - 1'b1;
                end
                expected_samples.push_back(s);
            end
            default: ;
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level = AMP_RESET;
            clear_tone();
            expected_samples.delete();
            mismatches      = 0;
            samples_checked = 0;
            samples_pending = 0;
        end
        else
        begin
            if (amplitude_we)
                level = amplitude;
            if (in_valid && in_ready)
                advance_tone(op, freq_hz, duration_ms);
            if (out_valid && out_ready)
            begin
                if (expected_samples.size() == 0)
                begin
                    $display("%0t: unexpected sample, expected none, got %0d", $time, sample);
                    mismatches++;
                end
                else
                begin
                    if (sample !== expected_samples[0])
                    begin
                        $display("%0t: sample mismatch, expected %0d, got %0d",
                                 $time, expected_samples[0], sample);
                        mismatches++;
                    end
                    void'(expected_samples.pop_front());
                    samples_checked++;
                end
            end
            samples_pending = expected_samples.size();
        end
    end

endmodule

### bench/square_wave_tone_generator_top_tb.sv
// testbench top of the square wave tone generator: stimulus, handshake pressure and verdict
module square_wave_tone_generator_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import swtg_pkg::*;

    localparam int SAMPLE_RATE = 22050;
    // the block takes op 3 and drops it; the package has no name for it
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    // up to two plays in the queue, the one at its head in progress
    localparam int DRAIN_CYCLES = 150;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int PHASE_ITEMS  = 420;

    logic clk;
    logic rst_n = 1'b0;

    logic                       in_valid     = 1'b0;
    logic                       in_ready;
    logic [OP_W-1:0]            op           = '0;
    logic [FREQ_W-1:0]          freq_hz      = '0;
    logic [DUR_W-1:0]           duration_ms  = '0;
    logic                       out_valid;
    logic                       out_ready    = 1'b0;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       amplitude_we = 1'b0;
    logic [AMP_W-1:0]           amplitude    = '0;

    int mismatches;
    int samples_pending;
    int samples_checked;

    // handshake pressure, in percent of cycles
    int idle_pct  = 0;
    int stall_pct = 0;

    int items_sent   = 0;
    int amp_settings = 0;
    int cycles       = 0;

    square_wave_tone_generator_top #(
        .SAMPLE_RATE(SAMPLE_RATE)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .op          (op),
        .freq_hz     (freq_hz),
        .duration_ms (duration_ms),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .sample      (sample),
        .amplitude_we(amplitude_we),
        .amplitude   (amplitude)
    );

    // the checker sees the same pins as the block and does all prediction
    tone_sample_checker #(
        .SAMPLE_RATE(SAMPLE_RATE)
    ) checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .op             (op),
        .freq_hz        (freq_hz),
        .duration_ms    (duration_ms),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .sample         (sample),
        .amplitude_we   (amplitude_we),
        .amplitude      (amplitude),
        .mismatches     (mismatches),
        .samples_pending(samples_pending),
        .samples_checked(samples_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver side: stall at random according to the current phase
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // watchdog: a hung handshake ends the run here
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d samples still expected",
                     cycles, samples_pending);
            $display("Verification failed");
            $finish;
        end
    end

    // one transfer on the input channel; called right after a rising edge,
    // returns right after the edge that took the item
    task automatic send_item(input logic [OP_W-1:0] kind, input logic [FREQ_W-1:0] f,
                             input logic [DUR_W-1:0] d);
        // sender gap: valid low for a random number of cycles
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        op          <= kind;
        freq_hz     <= f;
        duration_ms <= d;
        do
            @(posedge clk);
        while (!in_ready);
        if (kind != OP_UNUSED)
            items_sent++;
    endtask

    // ticks carry junk in the play-only fields, the block must ignore it
    task automatic send_ticks(input int count);
        repeat (count)
            send_item(OP_TICK, FREQ_W'($urandom), DUR_W'($urandom));
    endtask

    // drop valid and let every expected sample arrive, then give queued
    // plays and stops time to finish in the back end
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (samples_pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    // amplitude register write, only while the block is idle
    task automatic set_amplitude(input logic [AMP_W-1:0] value);
        amplitude_we <= 1'b1;
        amplitude    <= value;
        @(posedge clk);
        amplitude_we <= 1'b0;
        amp_settings++;
    endtask

    // random part: mostly a play with random content followed by a burst of
    // ticks, so timed tones run out and short half-waves toggle often;
    // the rest is stops, ignored op 3 and bare ticks
    task automatic run_random(input int target);
        int n;
        int r;
        int burst;
        logic [FREQ_W-1:0] f;
        logic [DUR_W-1:0]  d;
        n = 0;
        while (n < target)
        begin
            r = $urandom_range(99);
            if (r < 70)
            begin
                case ($urandom_range(4))
                    0:       f = FREQ_W'($urandom);                    // full range
                    1:       f = FREQ_W'($urandom_range(1000, 11025)); // half-wave 1 to 11
                    2:       f = FREQ_W'($urandom_range(11026, 65535)); // divides to 0
                    3:       f = FREQ_W'($urandom_range(1, 999));      // long half-waves
                    default: f = '0;                                   // rest
                endcase
                case ($urandom_range(19))
                    0, 1, 2: d = '0;                              // plays until the next play or stop
                    3, 4:    d = DUR_W'($urandom);                // full range
                    default: d = DUR_W'($urandom_range(1, 4));    // 22 to 88 samples
                endcase
                burst = $urandom_range(1, 40);
                send_item(OP_PLAY, f, d);
                send_ticks(burst);
                n += burst + 1;
                if ($urandom_range(9) == 0)
                begin
                    send_item(OP_STOP, FREQ_W'($urandom), DUR_W'($urandom));
                    n++;
                end
            end
            else if (r < 80)
            begin
                burst = $urandom_range(1, 5);
                send_item(OP_STOP, FREQ_W'($urandom), DUR_W'($urandom));
                send_ticks(burst);
                n += burst + 1;
            end
            else if (r < 88)
            begin
                // ignored by the block, does not count toward the target
                send_item(OP_UNUSED, FREQ_W'($urandom), DUR_W'($urandom));
            end
            else
            begin
                burst = $urandom_range(1, 10);
                send_ticks(burst);
                n += burst;
            end
        end
    endtask

    initial
    begin
        int idle_mix[4];
        int stall_mix[4];
        logic [AMP_W-1:0] amp_mix[4];
        idle_mix  = '{0, 58, 0, 26};
        stall_mix = '{0, 0, 58, 26};
        amp_mix   = '{15'h7FFF, 15'd0, 15'd1, AMP_W'($urandom)};

        // reset once, at the start
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, at the reset amplitude
        send_ticks(1);                                   // silent after reset
        send_item(OP_UNUSED, '1, '1);                    // op 3 with all ones, no effect
        send_ticks(1);
        send_item(OP_PLAY, '0, '0);                      // rest, plays on
        send_ticks(1);
        send_item(OP_PLAY, 16'd1000, '0);                // endless tone, half-wave 11
        send_ticks(1);
        send_item(OP_STOP, '1, '1);                      // stop clears the tone
        send_ticks(1);
        // top frequency forces half-wave 1; 1 ms is 22 samples, then silence
        send_item(OP_PLAY, '1, 16'd1);
        send_ticks(24);
        send_item(OP_PLAY, 16'd1, '1);                   // lowest tone, longest duration
        send_ticks(2);

        // random part in four pressure phases, amplitude rewritten between
        for (int p = 0; p < 4; p++)
        begin
            drain();
            set_amplitude(amp_mix[p]);
            idle_pct  = idle_mix[p];
            stall_pct = stall_mix[p];
            run_random(PHASE_ITEMS);
        end

        // wait out every expected sample plus the back end
        drain();

        $display("%0d items sent in four pressure phases, %0d samples checked",
                 items_sent, samples_checked);
        $display("%0d amplitude settings including 0 and full scale, %0d mismatches",
                 amp_settings, mismatches);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
